// ----- rtl/brf_pkg.sv -----
package brf_pkg;

   localparam int DATA_W = 8;
   localparam int CNT_W  = 7;
   localparam int FILL_W = 8;

   typedef enum logic [1:0] {
      REQ_WRITE   = 2'd0,
      REQ_READ    = 2'd1,
      REQ_DISCARD = 2'd2,
      REQ_CLEAR   = 2'd3
   } req_kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } brf_state_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [DATA_W-1:0] write_data;
      logic [CNT_W-1:0]  count;
   } req_beat_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              data_valid;
      logic [CNT_W-1:0]  done_count;
      logic              last;
      logic [FILL_W-1:0] fill_level;
   } rsp_beat_type;

endpackage

// ----- rtl/brf_ram.sv -----
module brf_ram #(
   parameter int AW = 8
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [brf_pkg::DATA_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [brf_pkg::DATA_W-1:0] rd_data
);
   import brf_pkg::*;

   logic [DATA_W-1:0] mem [0:(1<<AW)-1];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port: hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/brf_ctrl.sv -----
module brf_ctrl #(
   parameter int AW        = 8,
   parameter int MAX_BURST = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  brf_pkg::req_beat_type      req_beat,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output brf_pkg::rsp_beat_type      rsp_beat,
   output logic                       ram_wr_en,
   output logic [AW-1:0]              ram_wr_addr,
   output logic [brf_pkg::DATA_W-1:0] ram_wr_data,
   output logic                       ram_rd_en,
   output logic [AW-1:0]              ram_rd_addr,
   input  logic [brf_pkg::DATA_W-1:0] ram_rd_data
);
   import brf_pkg::*;

   localparam int MW = (AW > CNT_W) ? AW : CNT_W;
   localparam int FW = (AW > FILL_W) ? AW : FILL_W;

   brf_state_type    st_ff, st_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [AW-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0] done_ff, done_in;
   logic [CNT_W-1:0] total_ff, total_in;
   rsp_beat_type     rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             rsp_load;
   logic             out_free;
   logic             acc;
   logic [AW-1:0]    fill;
   logic [CNT_W-1:0] cnt_sat;
   logic [MW-1:0]    fill_m, cnt_m, n_m;
   logic [CNT_W-1:0] n_cnt;
   logic [AW-1:0]    n_idx;
   logic [CNT_W-1:0] done_nx;
   logic             last_pop;

   function automatic logic [FILL_W-1:0] fill8(input logic [AW-1:0] f);
      logic [FW-1:0] w;
      w = FW'(f);
      return w[FILL_W-1:0];
   endfunction

   assign fill     = head_ff - tail_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((st_ff == ST_IDLE) && out_free);
   assign acc      = req_valid && !req_stall;

   assign cnt_sat = (req_beat.count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : req_beat.count;
   assign fill_m  = MW'(fill);
   assign cnt_m   = MW'(cnt_sat);
   assign n_m     = (fill_m < cnt_m) ? fill_m : cnt_m;
   assign n_cnt   = n_m[CNT_W-1:0];
   assign n_idx   = n_m[AW-1:0];

   assign done_nx  = done_ff + CNT_W'(1);
   assign last_pop = (done_nx == total_ff);

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (acc && (req_beat.req_type == REQ_READ) && (n_cnt != '0)) begin
               st_in = ST_READ;
            end
         end
         ST_READ: begin
            if (out_free && last_pop) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      done_in     = done_ff;
      total_in    = total_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = head_ff;
      ram_wr_data = req_beat.write_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = tail_ff;
      rsp_load    = 1'b0;
      rsp_in      = rsp_ff;
      case (st_ff)
         ST_IDLE: begin
            if (acc) begin
               rsp_in.data       = '0;
               rsp_in.data_valid = 1'b0;
               rsp_in.done_count = '0;
               rsp_in.last       = 1'b1;
               rsp_in.fill_level = fill8(fill);
               case (req_kind_type'(req_beat.req_type))
                  REQ_WRITE: begin
                     rsp_load = 1'b1;
                     if ((head_ff + AW'(1)) != tail_ff) begin
                        ram_wr_en         = 1'b1;
                        head_in           = head_ff + AW'(1);
                        rsp_in.done_count = CNT_W'(1);
                        rsp_in.fill_level = fill8(fill + AW'(1));
                     end
                  end
                  REQ_READ: begin
                     if (n_cnt == '0) begin
                        rsp_load = 1'b1;
                     end else begin
                        ram_rd_en = 1'b1;
                        tail_in   = tail_ff + AW'(1);
                        total_in  = n_cnt;
                        done_in   = '0;
                     end
                  end
                  REQ_DISCARD: begin
                     rsp_load          = 1'b1;
                     tail_in           = tail_ff + n_idx;
                     rsp_in.done_count = n_cnt;
                     rsp_in.fill_level = fill8(fill - n_idx);
                  end
                  REQ_CLEAR: begin
                     rsp_load          = 1'b1;
                     head_in           = '0;
                     tail_in           = '0;
                     rsp_in.fill_level = '0;
                  end
                  default: rsp_load = 1'b0;
               endcase
            end
         end
         ST_READ: begin
            // tail already points past the byte in the read register
            if (out_free) begin
               rsp_load          = 1'b1;
               rsp_in.data       = ram_rd_data;
               rsp_in.data_valid = 1'b1;
               rsp_in.done_count = done_nx;
               rsp_in.last       = last_pop;
               rsp_in.fill_level = fill8(fill);
               done_in           = done_nx;
               if (!last_pop) begin
                  ram_rd_en = 1'b1;
                  tail_in   = tail_ff + AW'(1);
               end
            end
         end
         default: rsp_load = 1'b0;
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         done_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         done_ff      <= done_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

   a_burst_in_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_READ) |-> (done_ff < total_ff))
      else $error("burst counter ran past its length");

   a_not_last_only_in_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !rsp_in.last) |-> (st_ff == ST_READ))
      else $error("non-final beat outside a read burst");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (acc && (req_beat.req_type == REQ_CLEAR)) |=> (head_ff == '0 && tail_ff == '0))
      else $error("clear left an index set");

   a_no_write_in_burst: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_READ) |-> !ram_wr_en)
      else $error("ring written during a read burst");

endmodule

// ----- rtl/byte_ring_fifo_core.sv -----
// Byte ring FIFO: DEPTH-slot ring in one synchronous RAM, DEPTH-1 bytes usable.
// The result beat of a write, discard or clear is registered on acceptance; each byte
// of a read burst passes through the RAM read register and then the result register.
// Write/discard/clear take one request per cycle while the result port is not stalled;
// a read holds the request port for the whole burst, one byte per cycle unless stalled.
// Reset (synchronous, active high) zeroes head and tail; the ring contents are kept.
module byte_ring_fifo_core #(
   parameter int DEPTH     = 256,
   parameter int MAX_BURST = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  brf_pkg::req_beat_type req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output brf_pkg::rsp_beat_type rsp_beat
);
   import brf_pkg::*;

   // index width; DEPTH is a power of two
   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   // Sequencer: owns head/tail, the burst counters and the result register.
   // Only one RAM access per cycle is issued, and a write and a later read of
   // the same slot are always in different cycles, so no forwarding is needed.
   brf_ctrl #(
      .AW        (AW),
      .MAX_BURST (MAX_BURST)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_beat    (req_beat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // Ring storage: read data held in its output register while the result
   // register is stalled, so a burst simply pauses.
   brf_ram #(
      .AW (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ----- sim/byte_ring_fifo_core_tb.sv -----
module byte_ring_fifo_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import brf_pkg::*;

   localparam int RING_SLOTS = 256;
   localparam int BURST_CAP  = 64;
   localparam int LONG_HOLD  = 150;

   // one request waiting to be offered, with the idle cycles that follow it
   typedef struct {
      req_beat_type beat;
      int           gap_after;
      bit           drain_first;
   } queued_req_type;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_beat  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_beat;

   queued_req_type req_backlog[$];
   rsp_beat_type   due_beats[$];

   // shadow copy of the ring and its indices
   logic [DATA_W-1:0] shadow_ring[RING_SLOTS];
   logic [7:0]        shadow_head = '0;
   logic [7:0]        shadow_tail = '0;

   int reqs_taken   = 0;
   int hold_at      = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;
   int fail_count   = 0;
   int beats_seen   = 0;
   int full_refused = 0;
   int peak_fill    = 0;
   int kind_seen[4] = '{0, 0, 0, 0};

   byte_ring_fifo_core #(
      .DEPTH     (RING_SLOTS),
      .MAX_BURST (BURST_CAP)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Work out the result beats of one accepted request and queue them, oldest first.
   task automatic apply_fifo_request(input req_beat_type rq);
      logic [7:0]   fill_lvl;
      logic [7:0]   n;
      logic [6:0]   cnt;
      rsp_beat_type rb;
      cnt      = (rq.count > BURST_CAP) ? 7'(BURST_CAP) : rq.count;
      fill_lvl = shadow_head - shadow_tail;
      n        = (8'(cnt) < fill_lvl) ? 8'(cnt) : fill_lvl;
      rb       = '0;
      rb.last  = 1'b1;
      kind_seen[rq.req_type]++;
      case (rq.req_type)
         REQ_WRITE: begin
            // a full ring keeps one slot empty: drop the byte
            if (fill_lvl != 8'(RING_SLOTS - 1)) begin
               shadow_ring[shadow_head] = rq.write_data;
               shadow_head              = shadow_head + 8'd1;
               rb.done_count            = 7'd1;
            end else begin
               full_refused++;
            end
            rb.fill_level = shadow_head - shadow_tail;
            due_beats.push_back(rb);
         end
         REQ_READ: begin
            if (n == 8'd0) begin
               rb.fill_level = fill_lvl;
               due_beats.push_back(rb);
            end else begin
               for (int k = 1; k <= n; k++) begin
                  rb.data       = shadow_ring[shadow_tail];
                  rb.data_valid = 1'b1;
                  shadow_tail   = shadow_tail + 8'd1;
                  rb.done_count = 7'(k);
                  rb.last       = (k == n);
                  rb.fill_level = shadow_head - shadow_tail;
                  due_beats.push_back(rb);
               end
            end
         end
         REQ_DISCARD: begin
            shadow_tail   = shadow_tail + n;
            rb.done_count = n[6:0];
            rb.fill_level = shadow_head - shadow_tail;
            due_beats.push_back(rb);
         end
         default: begin
            // clear: indices back to zero, ring contents kept
            shadow_head   = '0;
            shadow_tail   = '0;
            rb.fill_level = '0;
            due_beats.push_back(rb);
         end
      endcase
      if (int'(fill_lvl) > peak_fill) peak_fill = int'(fill_lvl);
   endtask

   function automatic void add_req(input req_kind_type kind, input logic [7:0] wd,
                                   input logic [6:0] cnt, input int gap, input bit drain);
      queued_req_type q;
      q.beat.req_type   = kind;
      q.beat.write_data = wd;
      q.beat.count      = cnt;
      q.gap_after       = gap;
      q.drain_first     = drain;
      req_backlog.push_back(q);
   endfunction

   // mostly back-to-back or short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // mostly legal burst sizes, sometimes the whole field including zero and above the cap
   function automatic logic [6:0] pick_count();
      if ($urandom_range(0, 4) == 0) return 7'($urandom_range(0, 127));
      return 7'($urandom_range(1, BURST_CAP));
   endfunction

   // Driver: offer the backlog, hold the beat while stalled, advance on acceptance.
   always @(posedge clock) begin : drive_req
      queued_req_type nxt;
      int             idle_left;
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_fifo_request(req_beat);
            reqs_taken <= reqs_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0 &&
                         !(req_backlog[0].drain_first && due_beats.size() != 0)) begin
               nxt = req_backlog.pop_front();
               req_beat  <= nxt.beat;
               req_valid <= 1'b1;
               idle_left = nxt.gap_after;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off: once, while the sender streams writes, so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && hold_at != 0 && reqs_taken >= hold_at) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end
   end

   // Monitor: check each accepted result beat against the oldest one due, then pick the stall.
   always @(posedge clock) begin : watch_rsp
      rsp_beat_type want;
      int           stall_left;
      int           calm_left;
      int           r;
      bit           stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         calm_left  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beats_seen++;
            if (due_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected beat: data=%0h dv=%0b done=%0d last=%0b fill=%0d",
                           $realtime, rsp_beat.data, rsp_beat.data_valid,
                           rsp_beat.done_count, rsp_beat.last, rsp_beat.fill_level);
            end else begin
               want = due_beats.pop_front();
               if (rsp_beat.data !== want.data || rsp_beat.data_valid !== want.data_valid ||
                   rsp_beat.done_count !== want.done_count || rsp_beat.last !== want.last ||
                   rsp_beat.fill_level !== want.fill_level) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: beat mismatch", $realtime);
                     $display("   exp data=%0h dv=%0b done=%0d last=%0b fill=%0d",
                              want.data, want.data_valid, want.done_count,
                              want.last, want.fill_level);
                     $display("   got data=%0h dv=%0b done=%0d last=%0b fill=%0d",
                              rsp_beat.data, rsp_beat.data_valid, rsp_beat.done_count,
                              rsp_beat.last, rsp_beat.fill_level);
                  end
               end
            end
         end
         stall_next = 1'b0;
         if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else if (calm_left > 0) begin
            calm_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               calm_left = $urandom_range(5, 40);
            end else if (r < 92) begin
               stall_left = $urandom_range(0, 2);
               stall_next = 1'b1;
            end else begin
               stall_left = $urandom_range(15, 60);
               stall_next = 1'b1;
            end
         end
         rsp_stall <= stall_next || (hold_left != 0);
      end
   end

   initial begin
      int n_mixed;
      int run;
      int r;

      // directed: empty ring, zero counts, extremes of data, over-long bursts, clear
      add_req(REQ_READ,    8'h00, 7'd5,   pick_gap(), 1'b0);
      add_req(REQ_DISCARD, 8'h00, 7'd3,   pick_gap(), 1'b0);
      add_req(REQ_WRITE,   8'h00, 7'd1,   0,          1'b0);
      add_req(REQ_WRITE,   8'hFF, 7'd0,   0,          1'b0);
      add_req(REQ_WRITE,   8'hA5, 7'h7F,  pick_gap(), 1'b0);
      add_req(REQ_WRITE,   8'h5A, 7'd64,  pick_gap(), 1'b0);
      add_req(REQ_READ,    8'h00, 7'd0,   pick_gap(), 1'b0);
      add_req(REQ_DISCARD, 8'h00, 7'd0,   pick_gap(), 1'b0);
      add_req(REQ_READ,    8'hFF, 7'd2,   0,          1'b0);
      add_req(REQ_READ,    8'h00, 7'h7F,  pick_gap(), 1'b0);
      repeat (5) add_req(REQ_WRITE, 8'($urandom_range(0, 255)), 7'd1, 0, 1'b0);
      add_req(REQ_DISCARD, 8'h00, 7'h7F,  pick_gap(), 1'b0);
      repeat (3) add_req(REQ_WRITE, 8'($urandom_range(0, 255)), 7'd1, pick_gap(), 1'b0);
      add_req(REQ_CLEAR,   8'hFF, 7'h7F,  pick_gap(), 1'b1);
      add_req(REQ_READ,    8'h00, 7'd4,   pick_gap(), 1'b0);
      add_req(REQ_WRITE,   8'h3C, 7'd64,  pick_gap(), 1'b0);
      add_req(REQ_READ,    8'h00, 7'd1,   pick_gap(), 1'b0);

      // fill run: stream writes past full; the long hold-off lands early in it
      hold_at = req_backlog.size() + 10;
      add_req(REQ_WRITE, 8'($urandom_range(0, 255)), pick_count(), 0, 1'b1);
      for (int k = 1; k < 262; k++)
         add_req(REQ_WRITE, 8'($urandom_range(0, 255)), pick_count(),
                 ($urandom_range(0, 19) == 0) ? pick_gap() : 0, 1'b0);

      // mixed: mostly write runs closed by a read, the rest loose requests
      n_mixed = 0;
      while (n_mixed < 80) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            run = $urandom_range(1, 24);
            for (int k = 0; k < run; k++)
               add_req(REQ_WRITE, 8'($urandom_range(0, 255)), pick_count(), pick_gap(), 1'b0);
            add_req(REQ_READ, 8'($urandom_range(0, 255)),
                    ($urandom_range(0, 3) == 0) ? pick_count() : 7'(run), pick_gap(),
                    ($urandom_range(0, 24) == 0));
            n_mixed += run + 1;
         end else if (r < 72) begin
            add_req(REQ_READ, 8'($urandom_range(0, 255)), pick_count(), pick_gap(), 1'b0);
            n_mixed++;
         end else if (r < 86) begin
            add_req(REQ_DISCARD, 8'($urandom_range(0, 255)), pick_count(), pick_gap(), 1'b0);
            n_mixed++;
         end else if (r < 91) begin
            add_req(REQ_CLEAR, 8'($urandom_range(0, 255)), pick_count(), pick_gap(),
                    ($urandom_range(0, 1) == 0));
            n_mixed++;
         end else begin
            add_req(REQ_WRITE, 8'($urandom_range(0, 255)), pick_count(), pick_gap(), 1'b0);
            n_mixed++;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // drain: everything offered, accepted and answered
      while (req_backlog.size() != 0 || req_valid || due_beats.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d requests: %0d writes, %0d reads, %0d discards, %0d clears.",
               reqs_taken, kind_seen[REQ_WRITE], kind_seen[REQ_READ],
               kind_seen[REQ_DISCARD], kind_seen[REQ_CLEAR]);
      $display("Checked %0d result beats; %0d writes refused on a full ring; peak fill %0d.",
               beats_seen, full_refused, peak_fill);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches in total", fail_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #100ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
